### rtl/mdc_pkg.sv
// shared types, constants and saturation helper for the cofactor determinant block
package mdc_pkg;

    localparam int MAX_N_DEF = 8;
    localparam int SIZE_W    = 4;
    localparam int ELEM_W    = 32;
    localparam int DET_W     = 48;

    typedef logic signed [ELEM_W-1:0] elem_t;
    typedef logic signed [DET_W-1:0]  det_t;

    typedef struct packed {
        logic done;
        logic sat;
    } qmul_stat_t;

    // {saturated, value} for a sum one bit wider than a determinant word
    function automatic logic [DET_W:0] sat_det(input logic signed [DET_W:0] s);
        logic [DET_W:0] r;
        if (s[DET_W] != s[DET_W-1])
        begin
            r = {1'b1, s[DET_W], {(DET_W-1){~s[DET_W]}}};
        end
        else
        begin
            r = {1'b0, s[DET_W-1:0]};
        end
        return r;
    endfunction

endpackage

### rtl/mdc_ram.sv
// generic single-port-write ram with registered read
module mdc_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

### rtl/mdc_qmul.sv
// multi-cycle rounding fixed-point multiplier, element by determinant word
module mdc_qmul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  mdc_pkg::elem_t     a,
    input  mdc_pkg::det_t      b,
    output mdc_pkg::det_t      res,
    output mdc_pkg::qmul_stat_t stat
);
    import mdc_pkg::*;

    logic [1:0]        phase_reg, phase_next;
    logic [ELEM_W-1:0] ua_reg;
    logic [DET_W-1:0]  ub_reg;
    logic              neg_reg;
    logic [63:0]       p0_reg;
    logic [47:0]       p1_reg;
    det_t              res_reg;
    logic              done_reg, done_next;
    logic              sat_reg;
    logic [63:0]       m;
    logic [63:0]       lim;
    logic [63:0]       mc;
    logic              msat;

    always_comb
    begin
        m    = ((p0_reg + 64'h8000) >> 16) + {p1_reg, 16'h0};
        lim  = neg_reg ? 64'h8000_0000_0000 : 64'h7FFF_FFFF_FFFF;
        msat = m > lim;
        mc   = msat ? lim : m;
    end

    always_comb
    begin
        phase_next = phase_reg;
        done_next  = 1'b0;
        case (phase_reg)
            2'd0:
            begin
                if (start)
                begin
                    phase_next = 2'd1;
                end
            end
            2'd1: phase_next = 2'd2;
            2'd2: phase_next = 2'd3;
            default:
            begin
                phase_next = 2'd0;
                done_next  = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= 2'd0;
            done_reg  <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (phase_reg == 2'd0 && start)
        begin
            ua_reg  <= a[ELEM_W-1] ? (~a + 1'b1) : a;
            ub_reg  <= b[DET_W-1] ? (~b + 1'b1) : b;
            neg_reg <= a[ELEM_W-1] ^ b[DET_W-1];
        end
        if (phase_reg == 2'd1)
        begin
            p0_reg <= 64'(ua_reg) * 64'(ub_reg[31:0]);
        end
        if (phase_reg == 2'd2)
        begin
            p1_reg <= 48'(ua_reg) * 48'(ub_reg[47:32]);
        end
        if (phase_reg == 2'd3)
        begin
            res_reg <= neg_reg ? det_t'(~mc[DET_W-1:0] + 1'b1) : det_t'(mc[DET_W-1:0]);
            sat_reg <= msat;
        end
    end

    assign res       = res_reg;
    assign stat.done = done_reg;
    assign stat.sat  = sat_reg;
endmodule

### rtl/matrix_determinant_cofactor.sv
// top level: matrix store, expansion sequencer and result register
//
//  channel | signals                                  | request moves
//  cfg     | matrix_size_we, matrix_size               | order n, clears load
//  in      | in_valid, in_ready, elem_value            | one element, row-major
//  out     | out_valid, out_ready, det_value, overflow | determinant
//
// each element is taken on a handshake; the last one starts the expansion,
// which walks the cofactor tree depth first over the matrix store with one
// shared multiplier: n!/2 2 by 2 bases, each with two products, one product
// per term above the base and a step back per finished level.
// reset clears control state and sets n to 4; the store needs no clearing.
// no elements are taken during the expansion; a waiting result stalls it.
module matrix_determinant_cofactor #(
    parameter int MAX_N = mdc_pkg::MAX_N_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        matrix_size_we,
    input  logic [mdc_pkg::SIZE_W-1:0]  matrix_size,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  mdc_pkg::elem_t              elem_value,
    output logic                        out_valid,
    input  logic                        out_ready,
    output mdc_pkg::det_t               det_value,
    output logic                        overflow
);
    import mdc_pkg::*;

    localparam int DEPTH = MAX_N * MAX_N;
    localparam int AW    = $clog2(DEPTH);
    localparam int LW    = $clog2(DEPTH + 1);
    localparam int IW    = $clog2(MAX_N);
    localparam int CW    = $clog2(MAX_N + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_START = 4'd1;
    localparam logic [3:0] S_FIND  = 4'd2;
    localparam logic [3:0] S_RDA   = 4'd3;
    localparam logic [3:0] S_BRD   = 4'd4;
    localparam logic [3:0] S_BW1   = 4'd5;
    localparam logic [3:0] S_BW2   = 4'd6;
    localparam logic [3:0] S_MUL   = 4'd7;
    localparam logic [3:0] S_MWAIT = 4'd8;
    localparam logic [3:0] S_OUT   = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg, size_next;
    logic [LW-1:0]     lc_reg, lc_next;
    logic [IW-1:0]     lvl_reg, lvl_next;
    logic [2:0]        bi_reg, bi_next;
    logic              ovf_reg, ovf_next;
    logic              out_valid_reg, out_valid_next;
    det_t              det_reg, det_next;
    logic              oflag_reg, oflag_next;
    det_t              sub_reg, sub_next;
    det_t              p1_reg;
    logic [MAX_N-1:0]  bmask_reg;

    logic [MAX_N-1:0]  mask_reg [MAX_N];
    logic [CW-1:0]     col_reg  [MAX_N];
    det_t              d_reg    [MAX_N];
    logic              k_reg    [MAX_N];
    elem_t             a_reg    [MAX_N];
    elem_t             e_reg    [4];

    logic [SIZE_W-1:0] nsel;
    logic [7:0]        nn;
    logic              accept;
    logic [MAX_N-1:0]  full;
    logic [MAX_N-1:0]  cmask;
    logic [CW-1:0]     ccol;
    logic              found;
    logic [IW-1:0]     fidx;
    logic [IW-1:0]     c0, c1;
    logic [IW-1:0]     rrow, rcol;
    logic [7:0]        raddr_full;
    logic [AW-1:0]     raddr;
    logic [ELEM_W-1:0] rdata;
    logic              mstart;
    elem_t             ma;
    det_t              mb;
    det_t              mres;
    qmul_stat_t        mstat;
    logic [DET_W:0]    acc_sat;
    logic [DET_W:0]    base_sat;
    logic [MAX_N-1:0]  child;
    logic [SIZE_W-1:0] lvl_ext;

    always_comb
    begin
        if (size_reg < SIZE_W'(2))
        begin
            nsel = SIZE_W'(2);
        end
        else if (size_reg > SIZE_W'(MAX_N))
        begin
            nsel = SIZE_W'(MAX_N);
        end
        else
        begin
            nsel = size_reg;
        end
        nn = 8'(nsel) * 8'(nsel);
        for (int i = 0; i < MAX_N; i++)
        begin
            full[i] = SIZE_W'(i) < nsel;
        end
    end

    assign in_ready = state_reg == S_IDLE;
    assign accept   = in_valid && in_ready;
    assign lvl_ext  = SIZE_W'(lvl_reg);

    // next column at or after the current one at this level
    always_comb
    begin
        cmask = mask_reg[lvl_reg];
        ccol  = col_reg[lvl_reg];
        found = 1'b0;
        fidx  = '0;
        for (int i = MAX_N - 1; i >= 0; i--)
        begin
            if (cmask[i] && CW'(i) >= ccol)
            begin
                found = 1'b1;
                fidx  = IW'(i);
            end
        end
        child = cmask & ~(MAX_N'(1) << col_reg[lvl_reg]);
    end

    // two lowest free columns of the 2 by 2 base
    always_comb
    begin
        c0 = '0;
        c1 = '0;
        for (int i = MAX_N - 1; i >= 0; i--)
        begin
            if (bmask_reg[i])
            begin
                c0 = IW'(i);
            end
        end
        for (int i = MAX_N - 1; i >= 0; i--)
        begin
            if (bmask_reg[i] && IW'(i) > c0)
            begin
                c1 = IW'(i);
            end
        end
    end

    always_comb
    begin
        rrow = lvl_reg;
        rcol = fidx;
        if (state_reg == S_BRD)
        begin
            case (bi_reg)
                3'd0:
                begin
                    rrow = IW'(nsel - SIZE_W'(2));
                    rcol = c0;
                end
                3'd1:
                begin
                    rrow = IW'(nsel - SIZE_W'(1));
                    rcol = c1;
                end
                3'd2:
                begin
                    rrow = IW'(nsel - SIZE_W'(1));
                    rcol = c0;
                end
                default:
                begin
                    rrow = IW'(nsel - SIZE_W'(2));
                    rcol = c1;
                end
            endcase
        end
        raddr_full = 8'(rrow) * 8'(nsel) + 8'(rcol);
        raddr      = raddr_full[AW-1:0];
    end

    mdc_ram #(
        .WIDTH (ELEM_W),
        .DEPTH (DEPTH)
    ) u_store (
        .clk   (clk),
        .we    (accept),
        .waddr (lc_reg[AW-1:0]),
        .wdata (elem_value),
        .raddr (raddr),
        .rdata (rdata)
    );

    always_comb
    begin
        mstart = 1'b0;
        ma     = a_reg[lvl_reg];
        mb     = sub_reg;
        if (state_reg == S_BRD && bi_reg == 3'd4)
        begin
            mstart = 1'b1;
            ma     = e_reg[0];
            mb     = det_t'(e_reg[1]);
        end
        else if (state_reg == S_BW1 && mstat.done)
        begin
            mstart = 1'b1;
            ma     = e_reg[2];
            mb     = det_t'(e_reg[3]);
        end
        else if (state_reg == S_MUL)
        begin
            mstart = 1'b1;
        end
    end

    mdc_qmul u_qmul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mstart),
        .a     (ma),
        .b     (mb),
        .res   (mres),
        .stat  (mstat)
    );

    always_comb
    begin
        if (k_reg[lvl_reg])
        begin
            acc_sat = sat_det({d_reg[lvl_reg][DET_W-1], d_reg[lvl_reg]} - {mres[DET_W-1], mres});
        end
        else
        begin
            acc_sat = sat_det({d_reg[lvl_reg][DET_W-1], d_reg[lvl_reg]} + {mres[DET_W-1], mres});
        end
        base_sat = sat_det({p1_reg[DET_W-1], p1_reg} - {mres[DET_W-1], mres});
    end

    always_comb
    begin
        state_next     = state_reg;
        size_next      = size_reg;
        lc_next        = lc_reg;
        lvl_next       = lvl_reg;
        bi_next        = bi_reg;
        ovf_next       = ovf_reg;
        sub_next       = sub_reg;
        det_next       = det_reg;
        oflag_next     = oflag_reg;
        out_valid_next = out_valid_reg && !out_ready;
        if (matrix_size_we)
        begin
            size_next = matrix_size;
            lc_next   = '0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept && !matrix_size_we)
                begin
                    if (8'(lc_reg) + 8'd1 == nn)
                    begin
                        lc_next    = '0;
                        state_next = S_START;
                    end
                    else
                    begin
                        lc_next = lc_reg + 1'b1;
                    end
                end
            end
            S_START:
            begin
                lvl_next = '0;
                ovf_next = 1'b0;
                bi_next  = '0;
                state_next = (nsel == SIZE_W'(2)) ? S_BRD : S_FIND;
            end
            S_FIND:
            begin
                if (found)
                begin
                    state_next = S_RDA;
                end
                else if (lvl_reg == '0)
                begin
                    sub_next   = d_reg[0];
                    state_next = S_OUT;
                end
                else
                begin
                    sub_next   = d_reg[lvl_reg];
                    lvl_next   = lvl_reg - 1'b1;
                    state_next = S_MUL;
                end
            end
            S_RDA:
            begin
                if (lvl_ext + SIZE_W'(3) == nsel)
                begin
                    bi_next    = '0;
                    state_next = S_BRD;
                end
                else
                begin
                    lvl_next   = lvl_reg + 1'b1;
                    state_next = S_FIND;
                end
            end
            S_BRD:
            begin
                bi_next = bi_reg + 1'b1;
                if (bi_reg == 3'd4)
                begin
                    state_next = S_BW1;
                end
            end
            S_BW1:
            begin
                if (mstat.done)
                begin
                    ovf_next   = ovf_reg | mstat.sat;
                    state_next = S_BW2;
                end
            end
            S_BW2:
            begin
                if (mstat.done)
                begin
                    ovf_next = ovf_reg | mstat.sat | base_sat[DET_W];
                    sub_next = base_sat[DET_W-1:0];
                    if (nsel == SIZE_W'(2))
                    begin
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_MUL;
                    end
                end
            end
            S_MUL:
            begin
                state_next = S_MWAIT;
            end
            S_MWAIT:
            begin
                if (mstat.done)
                begin
                    ovf_next   = ovf_reg | mstat.sat | acc_sat[DET_W];
                    state_next = S_FIND;
                end
            end
            S_OUT:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next = 1'b1;
                    det_next       = sub_reg;
                    oflag_next     = ovf_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            size_reg      <= SIZE_W'(4);
            lc_reg        <= '0;
            lvl_reg       <= '0;
            bi_reg        <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            size_reg      <= size_next;
            lc_reg        <= lc_next;
            lvl_reg       <= lvl_next;
            bi_reg        <= bi_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // expansion stack and payload
    always_ff @(posedge clk)
    begin
        sub_reg   <= sub_next;
        det_reg   <= det_next;
        oflag_reg <= oflag_next;
        case (state_reg)
            S_START:
            begin
                mask_reg[0] <= full;
                col_reg[0]  <= '0;
                d_reg[0]    <= '0;
                k_reg[0]    <= 1'b0;
                bmask_reg   <= full;
            end
            S_FIND:
            begin
                if (found)
                begin
                    col_reg[lvl_reg] <= CW'(fidx);
                end
            end
            S_RDA:
            begin
                a_reg[lvl_reg] <= rdata;
                bmask_reg      <= child;
                if (lvl_ext + SIZE_W'(3) != nsel)
                begin
                    mask_reg[lvl_reg + 1'b1] <= child;
                    col_reg[lvl_reg + 1'b1]  <= '0;
                    d_reg[lvl_reg + 1'b1]    <= '0;
                    k_reg[lvl_reg + 1'b1]    <= 1'b0;
                end
            end
            S_BRD:
            begin
                if (bi_reg != 3'd0)
                begin
                    e_reg[2'(bi_reg - 3'd1)] <= rdata;
                end
            end
            S_BW1:
            begin
                if (mstat.done)
                begin
                    p1_reg <= mres;
                end
            end
            S_MWAIT:
            begin
                if (mstat.done)
                begin
                    d_reg[lvl_reg]   <= acc_sat[DET_W-1:0];
                    k_reg[lvl_reg]   <= ~k_reg[lvl_reg];
                    col_reg[lvl_reg] <= col_reg[lvl_reg] + 1'b1;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign det_value = det_reg;
    assign overflow  = oflag_reg;

    a_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mstat.done |-> (state_reg == S_BW1 || state_reg == S_BW2 || state_reg == S_MWAIT))
        else $error("multiplier result outside a wait state");

    a_load_bound: assert property (@(posedge clk) disable iff (!rst_n)
        8'(lc_reg) < nn)
        else $error("load count beyond matrix");

    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg != S_IDLE |-> (lvl_reg == '0 || lvl_ext + SIZE_W'(3) <= nsel))
        else $error("expansion level too deep");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT && out_valid_reg && !out_ready) |=> state_reg == S_OUT)
        else $error("result overwritten while waiting");
endmodule

### test/tb_matrix_determinant_cofactor.sv
// testbench for matrix_determinant_cofactor: random matrices checked against a cofactor predictor
`timescale 1ns / 100ps

module tb_matrix_determinant_cofactor;

    import mdc_pkg::*;

    localparam int       STALL_LIMIT = 2000000;
    localparam longint   DET_MAX     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint   DET_MIN     = -64'sh0000_8000_0000_0000;

    typedef struct {
        det_t det;
        logic ovf;
    } det_result_t;

    logic                clk;
    logic                rst_n;
    logic                matrix_size_we;
    logic [SIZE_W-1:0]   matrix_size;
    logic                in_valid;
    logic                in_ready;
    elem_t               elem_value;
    logic                out_valid;
    logic                out_ready;
    det_t                det_value;
    logic                overflow;

    elem_t               elem_q[$];
    det_result_t         det_q[$];

    int                  mstore[64];
    int unsigned         load_cnt;
    logic [SIZE_W-1:0]   size_reg;
    bit                  sat_seen;
    bit                  no_gaps;
    int                  in_gap;
    int                  out_gap;
    int                  stall_cnt;
    int                  fail_cnt;
    int                  elems_sent;

    matrix_determinant_cofactor uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .matrix_size_we (matrix_size_we),
        .matrix_size    (matrix_size),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .elem_value     (elem_value),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .det_value      (det_value),
        .overflow       (overflow)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (no_gaps || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 8);
    endfunction

    function automatic int unsigned order_of(logic [SIZE_W-1:0] s);
        if (s < 2)
            return 2;
        if (s > 8)
            return 8;
        return s;
    endfunction

    function automatic longint clip48(longint v);
        if (v > DET_MAX)
        begin
            sat_seen = 1'b1;
            return DET_MAX;
        end
        if (v < DET_MIN)
        begin
            sat_seen = 1'b1;
            return DET_MIN;
        end
        return v;
    endfunction

    // exact product, rounded half away from zero to 16 fraction bits, then clipped
    function automatic longint mul_q16(longint a, longint b);
        bit          neg;
        logic [95:0] ua;
        logic [95:0] ub;
        logic [95:0] m;
        logic [95:0] lim;
        neg = (a < 0) != (b < 0);
        ua  = (a < 0) ? 96'(-a) : 96'(a);
        ub  = (b < 0) ? 96'(-b) : 96'(b);
        m   = (ua * ub + 96'h8000) >> 16;
        lim = neg ? 96'h8000_0000_0000 : 96'h7FFF_FFFF_FFFF;
        if (m > lim)
        begin
            sat_seen = 1'b1;
            m = lim;
        end
        return neg ? -longint'(m[63:0]) : longint'(m[63:0]);
    endfunction

    function automatic longint elem_at(int unsigned n, int unsigned r, int unsigned c);
        return longint'(mstore[(r * n + c) % 64]);
    endfunction

    function automatic longint minor_det(int unsigned n, int unsigned row, logic [7:0] cols);
        int unsigned c0;
        int unsigned c1;
        int unsigned k;
        bit          got;
        longint      d;
        longint      t;
        c0 = 0;
        c1 = 0;
        k = 0;
        got = 1'b0;
        d = 0;
        if (n - row == 2)
        begin
            for (int c = 0; c < n; c++)
            begin
                if (cols[c])
                begin
                    if (!got)
                    begin
                        c0 = c;
                        got = 1'b1;
                    end
                    else
                    begin
                        c1 = c;
                        break;
                    end
                end
            end
            return clip48(mul_q16(elem_at(n, row, c0), elem_at(n, row + 1, c1))
                          - mul_q16(elem_at(n, row + 1, c0), elem_at(n, row, c1)));
        end
        for (int c = 0; c < n; c++)
        begin
            if (cols[c])
            begin
                t = mul_q16(elem_at(n, row, c), minor_det(n, row + 1, cols & ~(8'd1 << c)));
                d = clip48(k[0] ? d - t : d + t);
                k++;
            end
        end
        return d;
    endfunction

    task automatic load_element(elem_t v);
        int unsigned n;
        det_result_t r;
        n = order_of(size_reg);
        mstore[load_cnt % 64] = v;
        load_cnt = (load_cnt + 1) & 7'h7F;
        if (load_cnt >= n * n)
        begin
            load_cnt = 0;
            sat_seen = 1'b0;
            r.det = det_t'(minor_det(n, 0, 8'((1 << n) - 1)));
            r.ovf = sat_seen;
            det_q.push_back(r);
        end
    endtask

    // request driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid   <= 1'b0;
            elem_value <= '0;
            in_gap     <= 0;
        end
        else if (!in_valid || in_ready)
        begin
            if (in_gap > 0)
            begin
                in_valid <= 1'b0;
                in_gap   <= in_gap - 1;
            end
            else if (elem_q.size() > 0)
            begin
                in_valid   <= 1'b1;
                elem_value <= elem_q.pop_front();
                in_gap     <= pick_gap();
            end
            else
            begin
                in_valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else if (out_gap > 0)
        begin
            out_ready <= 1'b0;
            out_gap   <= out_gap - 1;
        end
        else
        begin
            out_ready <= 1'b1;
            if (!out_ready || out_valid)
                out_gap <= pick_gap();
        end
    end

    // monitor and watchdog
    always @(posedge clk)
    begin
        det_result_t e;
        bit          moved;
        moved = 1'b0;
        if (rst_n)
        begin
            if (matrix_size_we)
            begin
                size_reg = matrix_size;
                load_cnt = 0;
                moved = 1'b1;
            end
            if (in_valid && in_ready)
            begin
                load_element(elem_value);
                moved = 1'b1;
            end
            if (out_valid && out_ready)
            begin
                moved = 1'b1;
                if (det_q.size() == 0)
                begin
                    $error("unexpected determinant %0d", det_value);
                    fail_cnt++;
                end
                else
                begin
                    e = det_q.pop_front();
                    if (det_value !== e.det)
                    begin
                        $error("det_value expected %0d actual %0d", e.det, det_value);
                        fail_cnt++;
                    end
                    if (overflow !== e.ovf)
                    begin
                        $error("overflow expected %0b actual %0b", e.ovf, overflow);
                        fail_cnt++;
                    end
                end
            end
            stall_cnt <= moved ? 0 : stall_cnt + 1;
            if (stall_cnt >= STALL_LIMIT)
            begin
                $display("matrix_determinant_cofactor regression: fail");
                $finish;
            end
        end
    end

    function automatic elem_t gen_elem(int mode);
        case (mode)
            0: return elem_t'($urandom());
            1: return elem_t'(($signed($urandom_range(8)) - 4) * 65536);
            2: return elem_t'($signed($urandom_range(524288)) - 262144);
            default:
            begin
                case ($urandom_range(5))
                    0: return 32'h8000_0000;
                    1: return 32'h7FFF_FFFF;
                    2: return '0;
                    3: return '1;
                    4: return 32'h0001_0000;
                    default: return elem_t'($urandom());
                endcase
            end
        endcase
    endfunction

    task automatic wait_idle();
        do
            @(posedge clk);
        while (elem_q.size() > 0 || in_valid || det_q.size() > 0);
        repeat (40) @(posedge clk);
    endtask

    task automatic write_size(logic [SIZE_W-1:0] s);
        wait_idle();
        matrix_size_we <= 1'b1;
        matrix_size    <= s;
        @(posedge clk);
        matrix_size_we <= 1'b0;
    endtask

    task automatic send_matrices(int unsigned n, int count, int mode);
        for (int m = 0; m < count; m++)
        begin
            for (int i = 0; i < n * n; i++)
            begin
                elem_q.push_back(gen_elem(mode));
                elems_sent++;
            end
        end
    endtask

    initial
    begin
        int          sz;
        int          r;
        int unsigned n;
        fail_cnt       = 0;
        stall_cnt      = 0;
        elems_sent     = 0;
        load_cnt       = 0;
        size_reg       = 4'd4;
        no_gaps        = 1'b0;
        matrix_size_we = 1'b0;
        matrix_size    = 4'd4;
        rst_n          = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset order, extremes, discarded partial load, clamped orders
        send_matrices(4, 1, 3);
        write_size(4'd2);
        elem_q.push_back(32'h7FFF_FFFF);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'h8000_0000);
        elem_q.push_back(32'h7FFF_FFFF);
        write_size(4'd3);
        send_matrices(3, 1, 1);
        elem_q.push_back(32'h0001_0000);
        elem_q.push_back(32'h8000_0000);
        write_size(4'd0);
        send_matrices(2, 1, 1);
        write_size(4'd1);
        send_matrices(2, 1, 3);
        write_size(4'd15);
        send_matrices(8, 1, 2);
        write_size(4'd8);
        send_matrices(8, 1, 1);

        while (elems_sent < 1750)
        begin
            r = $urandom_range(99);
            if (r < 30)
                sz = 2;
            else if (r < 36)
                sz = $urandom_range(1);
            else if (r < 64)
                sz = 3;
            else if (r < 85)
                sz = 4;
            else if (r < 95)
                sz = 5;
            else if (r < 99)
                sz = 6;
            else
                sz = 7;
            write_size(4'(sz));
            no_gaps = ($urandom_range(3) == 0);
            n = order_of(4'(sz));
            send_matrices(n, $urandom_range(8, 1), $urandom_range(3));
            if ($urandom_range(9) == 0)
            begin
                for (int i = 0; i < $urandom_range(n * n - 1, 1); i++)
                    elem_q.push_back(gen_elem(0));
            end
        end

        wait_idle();
        repeat (200) @(posedge clk);
        if (fail_cnt == 0)
            $display("matrix_determinant_cofactor regression: pass");
        else
            $display("matrix_determinant_cofactor regression: fail");
        $finish;
    end

endmodule

### filelist.f
rtl/mdc_pkg.sv
rtl/mdc_ram.sv
rtl/mdc_qmul.sv
rtl/matrix_determinant_cofactor.sv
test/tb_matrix_determinant_cofactor.sv
